/* hw/rtl/mcsc_pkg.sv */
// Package for the motor current stall and collision monitor.
// Holds widths, codes, the controller state and command types and shared structs.
// No dependencies.
package mcsc_pkg;

  localparam int CHANNELS   = 2;
  localparam int CH_W       = 1;
  localparam int ACT_W      = 3;
  localparam int SAMPLE_W   = 16;
  localparam int Q_W        = 24;
  localparam int M2_W       = 48;
  localparam int CNT_W      = 32;
  localparam int AUC_W      = 16;
  localparam int PEAK_W     = 8;
  localparam int SIGMA_W    = 8;
  localparam int EVT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = 48;
  localparam int ROOT_STEPS = 24;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int ROOT_CNT_W = $clog2(ROOT_STEPS + 1);

  localparam int FLAG_LOW = 0;
  localparam int FLAG_UP  = 1;
  localparam int FLAG_GAP = 2;

  localparam logic [SIGMA_W-1:0] SIGMA_RESET   = 8'd48;
  localparam logic [PEAK_W-1:0]  PEAK_DISABLED = 8'd255;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE        = 3'd0,
    ACT_RESET_STATS   = 3'd1,
    ACT_RESET_EDGES   = 3'd2,
    ACT_ALLOW_PEAKS   = 3'd3,
    ACT_DISABLE_PEAKS = 3'd4,
    ACT_CLEAR_STALL   = 3'd5,
    ACT_SET_UPPER     = 3'd6
  } action_e;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE      = 2'd0,
    EVT_RUN       = 2'd1,
    EVT_STALL     = 2'd2,
    EVT_COLLISION = 2'd3
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_GAP = 2'd0,
    CFG_SIGMA  = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_BRANCH,
    ST_DIV_MEAN,
    ST_MEAN,
    ST_MULT,
    ST_M2,
    ST_DIV_VAR,
    ST_ROOT_START,
    ST_ROOT_WAIT,
    ST_SD_MUL,
    ST_UPPER,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_EVAL,
    CMD_STAT_INIT,
    CMD_MEAN,
    CMD_MULT,
    CMD_M2,
    CMD_ROOT,
    CMD_SD_MUL,
    CMD_UPPER
  } cmd_e;

  typedef struct packed {
    logic div_busy;
    logic root_busy;
    logic need_stats;
    logic cnt_gt1;
  } status_t;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic [Q_W-1:0]      value;
  } item_t;

  typedef struct packed {
    logic [EVT_W-1:0] event_res;
    logic [Q_W-1:0]   mean;
    logic [Q_W-1:0]   upper_threshold;
    logic [Q_W-1:0]   lower_threshold;
  } res_t;

endpackage

/* hw/rtl/mcsc_if.sv */
// Handshake interfaces for the monitor: sample items, results and configuration writes.
// Depends on mcsc_pkg.
interface mcsc_item_if;
  logic                          valid;
  logic                          ready;
  logic [mcsc_pkg::ACT_W-1:0]    action;
  logic [mcsc_pkg::CH_W-1:0]     channel;
  logic [mcsc_pkg::SAMPLE_W-1:0] sample;
  logic [mcsc_pkg::Q_W-1:0]      value;
  modport source (output valid, action, channel, sample, value, input ready);
  modport sink (input valid, action, channel, sample, value, output ready);
endinterface

interface mcsc_res_if;
  logic                       valid;
  logic                       ready;
  logic [mcsc_pkg::EVT_W-1:0] event_res;
  logic [mcsc_pkg::Q_W-1:0]   mean;
  logic [mcsc_pkg::Q_W-1:0]   upper_threshold;
  logic [mcsc_pkg::Q_W-1:0]   lower_threshold;
  modport source (output valid, event_res, mean, upper_threshold, lower_threshold, input ready);
  modport sink (input valid, event_res, mean, upper_threshold, lower_threshold, output ready);
endinterface

interface mcsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mcsc_pkg::CFG_IDX_W-1:0]  index;
  logic [mcsc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/mcsc_div.sv */
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor.
// Depends on mcsc_pkg.
module mcsc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mcsc_pkg::M2_W-1:0]   dividend_i,
  input  logic [mcsc_pkg::CNT_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [mcsc_pkg::M2_W-1:0]   quotient_o
);

  logic [mcsc_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [mcsc_pkg::M2_W-1:0]      quo_q, quo_d;
  logic [mcsc_pkg::CNT_W-1:0]     dvs_q, dvs_d;
  logic [mcsc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [mcsc_pkg::CNT_W:0]       rem_sh;
  logic                           ge;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;
  assign rem_sh     = {rem_q, quo_q[mcsc_pkg::M2_W-1]};
  assign ge         = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = mcsc_pkg::DIV_CNT_W'(mcsc_pkg::DIV_STEPS);
    end else if (busy_o) begin
      rem_d = ge ? mcsc_pkg::CNT_W'(rem_sh - {1'b0, dvs_q})
                 : mcsc_pkg::CNT_W'(rem_sh);
      quo_d = {quo_q[mcsc_pkg::M2_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

/* hw/rtl/mcsc_sqrt.sv */
// Integer square root of a 48-bit value, one result bit per cycle, giving a 24-bit root.
// Depends on mcsc_pkg.
module mcsc_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mcsc_pkg::M2_W-1:0]    radicand_i,
  output logic                         busy_o,
  output logic [mcsc_pkg::Q_W-1:0]     root_o
);

  logic [mcsc_pkg::M2_W-1:0]       v_q, v_d;
  logic [mcsc_pkg::M2_W-1:0]       res_q, res_d;
  logic [mcsc_pkg::M2_W-1:0]       bit_q, bit_d;
  logic [mcsc_pkg::ROOT_CNT_W-1:0] cnt_q, cnt_d;
  logic [mcsc_pkg::M2_W-1:0]       trial;

  assign busy_o = (cnt_q != '0);
  assign root_o = res_q[mcsc_pkg::Q_W-1:0];
  assign trial  = res_q + bit_q;

  always_comb begin
    v_d   = v_q;
    res_d = res_q;
    bit_d = bit_q;
    cnt_d = cnt_q;
    if (start_i) begin
      v_d   = radicand_i;
      res_d = '0;
      bit_d = mcsc_pkg::M2_W'(1) << (mcsc_pkg::M2_W - 2);
      cnt_d = mcsc_pkg::ROOT_CNT_W'(mcsc_pkg::ROOT_STEPS);
    end else if (busy_o) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

endmodule

/* hw/rtl/mcsc_dp.sv */
// Datapath: channel state, configuration registers, edge checks and the statistics update.
// Depends on mcsc_pkg, mcsc_div and mcsc_sqrt.
module mcsc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcsc_pkg::cmd_e                    cmd_i,
  output mcsc_pkg::status_t                 status_o,
  input  logic                              cfg_we_i,
  input  logic [mcsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcsc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  mcsc_pkg::item_t                   item_i,
  output mcsc_pkg::res_t                    res_o
);

  mcsc_pkg::item_t                 item_q;
  logic [mcsc_pkg::SAMPLE_W-1:0]   on_gap_q;
  logic [mcsc_pkg::SIGMA_W-1:0]    sigma_q;

  logic [mcsc_pkg::Q_W-1:0]        mean_q  [mcsc_pkg::CHANNELS];
  logic [mcsc_pkg::M2_W-1:0]       m2_q    [mcsc_pkg::CHANNELS];
  logic [mcsc_pkg::CNT_W-1:0]      cnt_q   [mcsc_pkg::CHANNELS];
  logic [mcsc_pkg::AUC_W-1:0]      auc_q   [mcsc_pkg::CHANNELS];
  logic [mcsc_pkg::PEAK_W-1:0]     peak_q  [mcsc_pkg::CHANNELS];
  logic [mcsc_pkg::Q_W-1:0]        upper_q [mcsc_pkg::CHANNELS];
  logic [mcsc_pkg::Q_W-1:0]        lower_q [mcsc_pkg::CHANNELS];
  logic [2:0]                      flags_q [mcsc_pkg::CHANNELS];
  logic                            run_q   [mcsc_pkg::CHANNELS];

  mcsc_pkg::event_e                evt_q;
  logic                            need_stats_q;
  logic                            dneg_q;
  logic [mcsc_pkg::Q_W-1:0]        dabs_q;
  logic [mcsc_pkg::Q_W-1:0]        d2abs_q;
  logic [mcsc_pkg::M2_W-1:0]       prod_q;
  logic [mcsc_pkg::CNT_W-1:0]      sdprod_q;

  logic [mcsc_pkg::CH_W-1:0]       ch;
  logic                            ch_ok;
  logic [mcsc_pkg::Q_W-1:0]        x;
  logic [mcsc_pkg::Q_W-1:0]        cur_mean;
  logic [mcsc_pkg::CNT_W-1:0]      cur_cnt;

  logic [2:0]                      ev_flags;
  logic [mcsc_pkg::AUC_W-1:0]      ev_auc;
  logic                            ev_run;
  mcsc_pkg::event_e                ev_evt;
  logic                            ev_stats;

  logic [mcsc_pkg::CNT_W-1:0]      cnt_inc;
  logic                            x_lt_mean;
  logic [mcsc_pkg::Q_W-1:0]        dabs_new;
  logic [mcsc_pkg::Q_W-1:0]        step;
  logic [mcsc_pkg::Q_W-1:0]        mean_new;
  logic [mcsc_pkg::Q_W-1:0]        d2abs_new;
  logic [mcsc_pkg::M2_W:0]         m2_sum;
  logic [mcsc_pkg::M2_W-1:0]       m2_new;
  logic [mcsc_pkg::Q_W+4:0]        up_sum;
  logic [mcsc_pkg::Q_W-1:0]        up_new;

  logic                            div_start;
  logic [mcsc_pkg::M2_W-1:0]       div_dividend;
  logic [mcsc_pkg::CNT_W-1:0]      div_divisor;
  logic                            div_busy;
  logic [mcsc_pkg::M2_W-1:0]       div_quo;
  logic                            root_start;
  logic                            root_busy;
  logic [mcsc_pkg::Q_W-1:0]        root_val;

  assign ch       = item_q.channel;
  assign ch_ok    = (32'(item_q.channel) < 32'(mcsc_pkg::CHANNELS));
  assign x        = {item_q.sample, 8'h00};
  assign cur_mean = mean_q[ch];
  assign cur_cnt  = cnt_q[ch];

  always_comb begin
    logic above_gap;
    logic below_low;
    logic above_up;
    ev_flags  = flags_q[ch];
    ev_auc    = auc_q[ch];
    ev_run    = run_q[ch];
    ev_evt    = mcsc_pkg::EVT_NONE;
    ev_stats  = 1'b0;
    above_gap = item_q.sample > on_gap_q;
    below_low = x < lower_q[ch];
    above_up  = x > upper_q[ch];
    if (above_gap && !ev_flags[mcsc_pkg::FLAG_GAP]) begin
      ev_evt = mcsc_pkg::EVT_RUN;
      ev_run = 1'b1;
    end
    ev_flags[mcsc_pkg::FLAG_GAP] = above_gap;
    if (below_low && !ev_flags[mcsc_pkg::FLAG_LOW]) begin
      ev_evt = mcsc_pkg::EVT_STALL;
      ev_auc = '0;
      ev_run = 1'b0;
    end
    ev_flags[mcsc_pkg::FLAG_LOW] = below_low;
    if (x > lower_q[ch]) begin
      if (above_up != ev_flags[mcsc_pkg::FLAG_UP]) begin
        if (above_up && above_gap) begin
          if (ev_auc > {8'h00, peak_q[ch]}) begin
            ev_evt = mcsc_pkg::EVT_COLLISION;
            ev_run = 1'b0;
          end
          if (ev_auc != '1) begin
            ev_auc = ev_auc + 1'b1;
          end
        end else begin
          ev_auc = '0;
        end
      end
      ev_flags[mcsc_pkg::FLAG_UP] = above_up;
      ev_stats = ev_run;
    end else begin
      ev_auc = '0;
    end
  end

  assign cnt_inc   = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
  assign x_lt_mean = x < cur_mean;
  assign dabs_new  = x_lt_mean ? cur_mean - x : x - cur_mean;
  assign step      = div_quo[mcsc_pkg::Q_W-1:0];
  assign mean_new  = dneg_q ? cur_mean - step : cur_mean + step;
  assign d2abs_new = (x >= mean_new) ? x - mean_new : mean_new - x;
  assign m2_sum    = {1'b0, m2_q[ch]} + {1'b0, prod_q};
  assign m2_new    = m2_sum[mcsc_pkg::M2_W] ? '1 : m2_sum[mcsc_pkg::M2_W-1:0];
  assign up_sum    = {5'b0, cur_mean} + {1'b0, sdprod_q[mcsc_pkg::CNT_W-1:4]};
  assign up_new    = (up_sum[mcsc_pkg::Q_W+4:mcsc_pkg::Q_W] != '0) ? '1
                                                               : up_sum[mcsc_pkg::Q_W-1:0];

  assign div_start    = (cmd_i == mcsc_pkg::CMD_STAT_INIT) ||
                        ((cmd_i == mcsc_pkg::CMD_M2) && (cur_cnt > 32'd1));
  assign div_dividend = (cmd_i == mcsc_pkg::CMD_STAT_INIT) ? {24'h0, dabs_new} : m2_new;
  assign div_divisor  = (cmd_i == mcsc_pkg::CMD_STAT_INIT) ? cnt_inc : cur_cnt - 1'b1;
  assign root_start   = (cmd_i == mcsc_pkg::CMD_ROOT);

  mcsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  mcsc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (div_quo),
    .busy_o     (root_busy),
    .root_o     (root_val)
  );

  assign status_o.div_busy   = div_busy;
  assign status_o.root_busy  = root_busy;
  assign status_o.need_stats = need_stats_q;
  assign status_o.cnt_gt1    = (cur_cnt > 32'd1);

  assign res_o.event_res       = evt_q;
  assign res_o.mean            = ch_ok ? cur_mean : '0;
  assign res_o.upper_threshold = ch_ok ? upper_q[ch] : '0;
  assign res_o.lower_threshold = ch_ok ? lower_q[ch] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_gap_q     <= '0;
      sigma_q      <= mcsc_pkg::SIGMA_RESET;
      evt_q        <= mcsc_pkg::EVT_NONE;
      need_stats_q <= 1'b0;
      for (int i = 0; i < mcsc_pkg::CHANNELS; i++) begin
        mean_q[i]  <= '0;
        m2_q[i]    <= '0;
        cnt_q[i]   <= mcsc_pkg::CNT_W'(1);
        auc_q[i]   <= '0;
        peak_q[i]  <= '0;
        upper_q[i] <= '0;
        lower_q[i] <= '0;
        flags_q[i] <= '0;
        run_q[i]   <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (mcsc_pkg::cfg_reg_e'(cfg_idx_i))
          mcsc_pkg::CFG_ON_GAP: on_gap_q <= cfg_data_i;
          mcsc_pkg::CFG_SIGMA:  sigma_q  <= cfg_data_i[mcsc_pkg::SIGMA_W-1:0];
          default: ;
        endcase
      end
      case (cmd_i)
        mcsc_pkg::CMD_EVAL: begin
          evt_q        <= mcsc_pkg::EVT_NONE;
          need_stats_q <= 1'b0;
          if (ch_ok) begin
            unique case (mcsc_pkg::action_e'(item_q.action))
              mcsc_pkg::ACT_SAMPLE: begin
                flags_q[ch]  <= ev_flags;
                auc_q[ch]    <= ev_auc;
                run_q[ch]    <= ev_run;
                evt_q        <= ev_evt;
                need_stats_q <= ev_stats;
              end
              mcsc_pkg::ACT_RESET_STATS: begin
                mean_q[ch] <= item_q.value;
                m2_q[ch]   <= '0;
                cnt_q[ch]  <= mcsc_pkg::CNT_W'(1);
              end
              mcsc_pkg::ACT_RESET_EDGES: begin
                flags_q[ch] <= 3'(1 << mcsc_pkg::FLAG_LOW);
              end
              mcsc_pkg::ACT_ALLOW_PEAKS:   peak_q[ch] <= '0;
              mcsc_pkg::ACT_DISABLE_PEAKS: peak_q[ch] <= mcsc_pkg::PEAK_DISABLED;
              mcsc_pkg::ACT_CLEAR_STALL: begin
                flags_q[ch][mcsc_pkg::FLAG_LOW] <= 1'b0;
              end
              mcsc_pkg::ACT_SET_UPPER: upper_q[ch] <= item_q.value;
              default: ;
            endcase
          end
        end
        mcsc_pkg::CMD_STAT_INIT: cnt_q[ch] <= cnt_inc;
        mcsc_pkg::CMD_MEAN: begin
          mean_q[ch]  <= mean_new;
          lower_q[ch] <= mean_new >> 2;
        end
        mcsc_pkg::CMD_M2:    m2_q[ch]    <= m2_new;
        mcsc_pkg::CMD_UPPER: upper_q[ch] <= up_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == mcsc_pkg::CMD_CAPTURE) begin
      item_q <= item_i;
    end
    if (cmd_i == mcsc_pkg::CMD_STAT_INIT) begin
      dneg_q <= x_lt_mean;
      dabs_q <= dabs_new;
    end
    if (cmd_i == mcsc_pkg::CMD_MEAN) begin
      d2abs_q <= d2abs_new;
    end
    if (cmd_i == mcsc_pkg::CMD_MULT) begin
      prod_q <= dabs_q * d2abs_q;
    end
    if (cmd_i == mcsc_pkg::CMD_SD_MUL) begin
      sdprod_q <= root_val * sigma_q;
    end
  end

endmodule

/* hw/rtl/mcsc_ctrl.sv */
// Controller state machine that sequences one transaction through the datapath.
// Depends on mcsc_pkg.
module mcsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  output logic              out_load_o,
  input  mcsc_pkg::status_t status_i,
  output mcsc_pkg::cmd_e    cmd_o
);

  mcsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    cmd_o      = mcsc_pkg::CMD_NONE;
    unique case (state_q)
      mcsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = mcsc_pkg::CMD_CAPTURE;
          state_d = mcsc_pkg::ST_EVAL;
        end
      end
      mcsc_pkg::ST_EVAL: begin
        cmd_o   = mcsc_pkg::CMD_EVAL;
        state_d = mcsc_pkg::ST_BRANCH;
      end
      mcsc_pkg::ST_BRANCH: begin
        if (status_i.need_stats) begin
          cmd_o   = mcsc_pkg::CMD_STAT_INIT;
          state_d = mcsc_pkg::ST_DIV_MEAN;
        end else begin
          state_d = mcsc_pkg::ST_DONE;
        end
      end
      mcsc_pkg::ST_DIV_MEAN: begin
        if (!status_i.div_busy) begin
          state_d = mcsc_pkg::ST_MEAN;
        end
      end
      mcsc_pkg::ST_MEAN: begin
        cmd_o   = mcsc_pkg::CMD_MEAN;
        state_d = mcsc_pkg::ST_MULT;
      end
      mcsc_pkg::ST_MULT: begin
        cmd_o   = mcsc_pkg::CMD_MULT;
        state_d = mcsc_pkg::ST_M2;
      end
      mcsc_pkg::ST_M2: begin
        cmd_o   = mcsc_pkg::CMD_M2;
        state_d = status_i.cnt_gt1 ? mcsc_pkg::ST_DIV_VAR : mcsc_pkg::ST_DONE;
      end
      mcsc_pkg::ST_DIV_VAR: begin
        if (!status_i.div_busy) begin
          state_d = mcsc_pkg::ST_ROOT_START;
        end
      end
      mcsc_pkg::ST_ROOT_START: begin
        cmd_o   = mcsc_pkg::CMD_ROOT;
        state_d = mcsc_pkg::ST_ROOT_WAIT;
      end
      mcsc_pkg::ST_ROOT_WAIT: begin
        if (!status_i.root_busy) begin
          state_d = mcsc_pkg::ST_SD_MUL;
        end
      end
      mcsc_pkg::ST_SD_MUL: begin
        cmd_o   = mcsc_pkg::CMD_SD_MUL;
        state_d = mcsc_pkg::ST_UPPER;
      end
      mcsc_pkg::ST_UPPER: begin
        cmd_o   = mcsc_pkg::CMD_UPPER;
        state_d = mcsc_pkg::ST_DONE;
      end
      mcsc_pkg::ST_DONE: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = mcsc_pkg::ST_IDLE;
        end
      end
      default: state_d = mcsc_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/motor_current_stall_collision_monitor.sv */
// Top level of the two-channel motor current stall and collision monitor.
// Depends on mcsc_pkg, mcsc_if, mcsc_ctrl and mcsc_dp.
//
//   port    direction  transaction
//   item_i  sink       action, channel, sample, value
//   res_o   source     event_res, mean, upper_threshold, lower_threshold
//   cfg_i   sink       index, data (register write)
//
// An item without a statistics update is captured, evaluated and then loaded into the
// result register once it is free. An item with one also makes two 48-step passes through
// the shared divider and a 24-step square root before its result is loaded.
// One item is in work at a time; the result register lets the next item enter while the
// previous result waits. Configuration writes are always taken. Reset is asynchronous.
module motor_current_stall_collision_monitor (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcsc_item_if.sink  item_i,
  mcsc_res_if.source res_o,
  mcsc_cfg_if.sink   cfg_i
);

  mcsc_pkg::status_t status;
  mcsc_pkg::cmd_e    cmd;
  mcsc_pkg::item_t   item;
  mcsc_pkg::res_t    res;
  mcsc_pkg::res_t    res_q;
  logic              out_valid_q;
  logic              out_free;
  logic              out_load;

  assign item.action  = item_i.action;
  assign item.channel = item_i.channel;
  assign item.sample  = item_i.sample;
  assign item.value   = item_i.value;

  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || res_o.ready;

  mcsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcsc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .item_i     (item),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.event_res       = res_q.event_res;
  assign res_o.mean            = res_q.mean;
  assign res_o.upper_threshold = res_q.upper_threshold;
  assign res_o.lower_threshold = res_q.lower_threshold;

endmodule

/* hw/rtl/mcsc_chk.sv */
// Port-level checker for the monitor, attached to the top level by a bind statement.
// Depends on mcsc_pkg and motor_current_stall_collision_monitor.
module mcsc_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [mcsc_pkg::EVT_W-1:0] out_event_i,
  input logic [mcsc_pkg::Q_W-1:0]   out_mean_i,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_i
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  // A waiting result holds its value until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_event_i) && $stable(out_mean_i))
    else $error("result changed while stalled");

  // One transaction is in work at a time, so no input is accepted while one is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i ##1 !in_ready_i)
    else $error("input taken while a transaction is in work");

  // A new result appears only when the work on its transaction is finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result appeared while a transaction was in work");

  // Configuration writes are never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind motor_current_stall_collision_monitor mcsc_chk u_mcsc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_event_i (res_o.event_res),
  .out_mean_i  (res_o.mean),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);
